FILE: hdl/depth_order_sorter_unit_macros.svh
// Assertion macros for the depth order sorter.
`ifndef DEPTH_ORDER_SORTER_UNIT_MACROS_SVH
`define DEPTH_ORDER_SORTER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define DOS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("depth order sorter: same-cycle check failed");

// Next-cycle implication, disabled while in reset.
`define DOS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("depth order sorter: next-cycle check failed");

`endif

FILE: hdl/dos_pkg.sv
// Package: types, codes and sizes shared by the depth order sorter.
`timescale 1ns / 1ps
`default_nettype none

package dos_pkg;

    localparam int CAPACITY = 512;
    localparam int COUNT_W  = $clog2(CAPACITY + 1);
    localparam int INDEX_W  = 9;
    localparam int DEPTH_W  = 16;

    // action codes
    localparam logic [1:0] ACT_CLEAR  = 2'd0;
    localparam logic [1:0] ACT_INSERT = 2'd1;
    localparam logic [1:0] ACT_POP    = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // command broadcast to every cell of the chain
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_CLEAR,
        OP_INSERT,
        OP_POP
    } dos_op_t;

    typedef struct packed {
        logic                      valid;
        logic [INDEX_W-1:0]        index;
        logic signed [DEPTH_W-1:0] depth;
    } entry_t;

    typedef struct packed {
        logic [1:0]                action;
        logic [INDEX_W-1:0]        point_index;
        logic signed [DEPTH_W-1:0] depth;
    } in_item_t;

    typedef struct packed {
        logic [1:0]                status;
        logic [INDEX_W-1:0]        out_index;
        logic signed [DEPTH_W-1:0] out_depth;
    } out_item_t;

endpackage

`default_nettype wire

FILE: hdl/dos_cell.sv
// One compare-and-shift cell of the sorted chain.
`timescale 1ns / 1ps
`default_nettype none

module dos_cell (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire dos_pkg::dos_op_t op,
    input  wire dos_pkg::entry_t  new_entry,
    input  wire dos_pkg::entry_t  left_entry,
    input  wire logic             left_after,
    input  wire dos_pkg::entry_t  right_entry,
    output dos_pkg::entry_t       entry,
    output logic                  after
);
    import dos_pkg::*;

    logic                      valid_reg;
    logic                      valid_next;
    logic [INDEX_W-1:0]        index_reg;
    logic [INDEX_W-1:0]        index_next;
    logic signed [DEPTH_W-1:0] depth_reg;
    logic signed [DEPTH_W-1:0] depth_next;

    // new key goes at or before this cell unless this cell holds a key <= it
    assign after = !(valid_reg && (depth_reg <= new_entry.depth));

    assign entry.valid = valid_reg;
    assign entry.index = index_reg;
    assign entry.depth = depth_reg;

    always_comb
    begin
        valid_next = valid_reg;
        index_next = index_reg;
        depth_next = depth_reg;
        case (op)
            OP_CLEAR:
            begin
                valid_next = 1'b0;
            end
            OP_INSERT:
            begin
                if (after && left_after)
                begin
                    valid_next = left_entry.valid;
                    index_next = left_entry.index;
                    depth_next = left_entry.depth;
                end
                else if (after)
                begin
                    valid_next = 1'b1;
                    index_next = new_entry.index;
                    depth_next = new_entry.depth;
                end
            end
            OP_POP:
            begin
                valid_next = right_entry.valid;
                index_next = right_entry.index;
                depth_next = right_entry.depth;
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        index_reg <= index_next;
        depth_reg <= depth_next;
    end

endmodule

`default_nettype wire

FILE: hdl/depth_order_sorter_unit.sv
// Top level: stable depth-sorting queue built as a chain of compare-and-shift cells.
`timescale 1ns / 1ps
`default_nettype none
`include "depth_order_sorter_unit_macros.svh"

// Depth order sorter. Keeps up to CAPACITY (512) points in ascending depth
// order, one point per cell of a linear chain; cell 0 always holds the
// smallest depth. Each input item is a clear, an insert or a pop. An insert
// is broadcast to all cells at once: every cell compares its own key with
// the new one and either keeps its entry, takes the new point, or takes its
// left neighbor's entry, so the point lands after all equal depths (equal
// depths pop in insertion order). A pop returns cell 0 and every cell takes
// its right neighbor's entry. Clear drops all valid flags together.
// Insert into a full chain returns status 1, pop from an empty chain status 2;
// neither changes the store. Action code 3 is a no-op with status 0.
// Every item produces exactly one result item; out_index and out_depth are
// zero except on a successful pop. Timing: one item per clock cycle unless
// stalled, result registered in the cycle after acceptance. The per-cycle path is
// one 16-bit signed compare per cell plus the neighbor select. in_ready drops
// only while a result waits and out_ready is low. No clearing pass after
// reset: reset clears the cell valid flags directly.
module depth_order_sorter_unit (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire dos_pkg::in_item_t in_item,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output dos_pkg::out_item_t     out_item
);
    import dos_pkg::*;

    // chain wiring
    entry_t              cell_entry [CAPACITY];
    logic [CAPACITY-1:0] cell_after;
    logic [CAPACITY-1:0] valid_vec;
    entry_t              new_entry;
    entry_t              empty_entry;
    dos_op_t             op;

    // occupancy and output register
    logic [COUNT_W-1:0]  fill_count_reg;
    logic [COUNT_W-1:0]  fill_count_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    out_item_t           out_item_reg;
    out_item_t           out_item_next;

    logic                in_fire;
    logic                out_fire;
    logic                full;
    logic                empty;

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid_reg && out_ready;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    assign full  = (fill_count_reg == COUNT_W'(CAPACITY));
    assign empty = !cell_entry[0].valid;

    assign new_entry.valid   = 1'b1;
    assign new_entry.index   = in_item.point_index;
    assign new_entry.depth   = in_item.depth;
    assign empty_entry       = '0;

    // command for the chain
    always_comb
    begin
        op = OP_HOLD;
        if (in_fire)
        begin
            case (in_item.action)
                ACT_CLEAR:  op = OP_CLEAR;
                ACT_INSERT: op = full ? OP_HOLD : OP_INSERT;
                ACT_POP:    op = empty ? OP_HOLD : OP_POP;
                default:    op = OP_HOLD;
            endcase
        end
    end

    // the chain itself
    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            entry_t left_e;
            logic   left_a;
            entry_t right_e;

            if (g == 0)
            begin : g_head
                assign left_e = empty_entry;
                assign left_a = 1'b0;
            end
            else
            begin : g_mid_l
                assign left_e = cell_entry[g-1];
                assign left_a = cell_after[g-1];
            end

            if (g == CAPACITY - 1)
            begin : g_tail
                assign right_e = empty_entry;
            end
            else
            begin : g_mid_r
                assign right_e = cell_entry[g+1];
            end

            dos_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .op          (op),
                .new_entry   (new_entry),
                .left_entry  (left_e),
                .left_after  (left_a),
                .right_entry (right_e),
                .entry       (cell_entry[g]),
                .after       (cell_after[g])
            );

            assign valid_vec[g] = cell_entry[g].valid;
        end
    endgenerate

    // fill count follows the chain
    always_comb
    begin
        fill_count_next = fill_count_reg;
        case (op)
            OP_CLEAR:  fill_count_next = '0;
            OP_INSERT: fill_count_next = fill_count_reg + COUNT_W'(1);
            OP_POP:    fill_count_next = fill_count_reg - COUNT_W'(1);
            default:   fill_count_next = fill_count_reg;
        endcase
    end

    // result item
    always_comb
    begin
        out_item_next = '0;
        if (in_item.action == ACT_INSERT && full)
        begin
            out_item_next.status = ST_FULL;
        end
        else if (in_item.action == ACT_POP && empty)
        begin
            out_item_next.status = ST_EMPTY;
        end
        else if (in_item.action == ACT_POP)
        begin
            out_item_next.status    = ST_OK;
            out_item_next.out_index = cell_entry[0].index;
            out_item_next.out_depth = cell_entry[0].depth;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_fire)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            fill_count_reg <= fill_count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            out_item_reg <= out_item_next;
        end
    end

    // checks
    `DOS_ASSERT_NOW(a_count_empty, clk, rst_n, 1'b1, ((fill_count_reg == '0) == !valid_vec[0]))
    `DOS_ASSERT_NOW(a_count_full, clk, rst_n, 1'b1, (full == valid_vec[CAPACITY-1]))
    `DOS_ASSERT_NOW(a_head_sorted, clk, rst_n, valid_vec[1],
        (cell_entry[0].depth <= cell_entry[1].depth))
    `DOS_ASSERT_NEXT(a_pop_ok, clk, rst_n, (in_fire && op == OP_POP),
        (out_valid_reg && out_item_reg.status == ST_OK))

endmodule

`default_nettype wire
